[rtl/srx_pkg.sv]
package srx_pkg;

    localparam int NAME_MAX_BYTES = 256;
    localparam int LEN_W          = $clog2(NAME_MAX_BYTES);
    localparam int INDEX_W        = 8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_DQ    = 8'h22;
    localparam logic [7:0] CHAR_SQ    = 8'h27;

    localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(NAME_MAX_BYTES - 1);
    localparam logic [INDEX_W-1:0] INDEX_SAT = '1;

    localparam logic [1:0] OMODE_NONE     = 2'd0;
    localparam logic [1:0] OMODE_TRUNCATE = 2'd1;
    localparam logic [1:0] OMODE_APPEND   = 2'd2;

    typedef struct packed {
        logic [7:0] line_char;
        logic       end_of_line;
    } srx_in_t;

    typedef struct packed {
        logic [7:0]         out_char;
        logic               name_valid;
        logic               name_target;
        logic [INDEX_W-1:0] name_index;
        logic               line_done;
        logic               parse_error;
        logic               input_mode;
        logic [1:0]         output_mode;
    } srx_out_t;

    function automatic logic [INDEX_W-1:0] sat_index(logic [LEN_W-1:0] len);
        logic [31:0] len32;
        len32 = 32'(len);
        if (len32 > 32'(INDEX_SAT)) begin
            return INDEX_SAT;
        end
        return len32[INDEX_W-1:0];
    endfunction

endpackage

[rtl/srx_parse.sv]
module srx_parse (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  srx_pkg::srx_in_t in_beat,
    output srx_pkg::srx_out_t out_beat
);
    import srx_pkg::*;

    typedef enum logic [5:0] {
        PH_NORMAL   = 6'b000001,
        PH_AFTER_GT = 6'b000010,
        PH_SKIP     = 6'b000100,
        PH_BARE     = 6'b001000,
        PH_QUOTED   = 6'b010000,
        PH_ERROR    = 6'b100000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             qopen_reg, qopen_next;
    logic             qdq_reg, qdq_next;
    logic             tgt_reg, tgt_next;
    logic             app_reg, app_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             imode_reg, imode_next;
    logic [1:0]       omode_reg, omode_next;
    logic             err_reg, err_next;

    logic [7:0] c;
    logic       is_blank, is_quote, is_op, closes_quote;
    logic       do_skip, do_normal, do_store;

    assign c        = in_beat.line_char;
    assign is_blank = c inside {CHAR_SPACE, CHAR_TAB};
    assign is_quote = c inside {CHAR_DQ, CHAR_SQ};
    assign is_op    = c inside {CHAR_LT, CHAR_GT, CHAR_PIPE};
    assign closes_quote = qopen_reg && (qdq_reg ? (c == CHAR_DQ) : (c == CHAR_SQ));

    always_comb begin
        phase_next = phase_reg;
        qopen_next = qopen_reg;
        qdq_next   = qdq_reg;
        tgt_next   = tgt_reg;
        app_next   = app_reg;
        len_next   = len_reg;
        imode_next = imode_reg;
        omode_next = omode_reg;
        err_next   = err_reg;
        do_skip    = 1'b0;
        do_normal  = 1'b0;
        do_store   = 1'b0;
        out_beat   = '0;
        out_beat.out_char = c;

        case (phase_reg)
            PH_AFTER_GT: begin
                phase_next = PH_SKIP;
                if (c == CHAR_GT) begin
                    out_beat.out_char = CHAR_SPACE;
                    app_next          = 1'b1;
                end else begin
                    do_skip = 1'b1;
                end
            end
            PH_SKIP: begin
                do_skip = 1'b1;
            end
            PH_BARE: begin
                if (is_blank || is_op) begin
                    if (tgt_reg) begin
                        omode_next = app_reg ? OMODE_APPEND : OMODE_TRUNCATE;
                    end else begin
                        imode_next = 1'b1;
                    end
                    phase_next = PH_NORMAL;
                    do_normal  = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_QUOTED: begin
                if (closes_quote) begin
                    qopen_next = 1'b0;
                    if (len_reg == '0) begin
                        err_next   = 1'b1;
                        phase_next = PH_ERROR;
                    end else begin
                        out_beat.out_char = CHAR_SPACE;
                        if (tgt_reg) begin
                            omode_next = app_reg ? OMODE_APPEND : OMODE_TRUNCATE;
                        end else begin
                            imode_next = 1'b1;
                        end
                        phase_next = PH_NORMAL;
                    end
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_ERROR: begin
            end
            default: begin
                phase_next = PH_NORMAL;
                do_normal  = 1'b1;
            end
        endcase

        if (do_skip) begin
            if (is_blank) begin
                out_beat.out_char = CHAR_SPACE;
            end else if (is_quote) begin
                out_beat.out_char = CHAR_SPACE;
                qopen_next = 1'b1;
                qdq_next   = (c == CHAR_DQ);
                len_next   = '0;
                phase_next = PH_QUOTED;
            end else if (is_op) begin
                err_next   = 1'b1;
                phase_next = PH_ERROR;
                qopen_next = 1'b0;
            end else begin
                phase_next = PH_BARE;
                out_beat.out_char    = CHAR_SPACE;
                out_beat.name_valid  = 1'b1;
                out_beat.name_target = tgt_reg;
                out_beat.name_index  = '0;
                len_next = LEN_W'(1);
            end
        end

        if (do_store) begin
            out_beat.out_char = CHAR_SPACE;
            if (len_reg < LEN_LIMIT) begin
                out_beat.name_valid  = 1'b1;
                out_beat.name_target = tgt_reg;
                out_beat.name_index  = sat_index(len_reg);
                len_next = len_reg + LEN_W'(1);
            end
        end

        if (do_normal) begin
            if (qopen_reg) begin
                if (closes_quote) begin
                    qopen_next = 1'b0;
                end
            end else if (is_quote) begin
                qopen_next = 1'b1;
                qdq_next   = (c == CHAR_DQ);
            end else if (c == CHAR_GT || c == CHAR_LT) begin
                out_beat.out_char = CHAR_SPACE;
                tgt_next   = (c == CHAR_GT);
                app_next   = 1'b0;
                len_next   = '0;
                phase_next = (c == CHAR_GT) ? PH_AFTER_GT : PH_SKIP;
            end
        end

        if (in_beat.end_of_line) begin
            if (phase_next == PH_AFTER_GT || phase_next == PH_SKIP ||
                (phase_next == PH_QUOTED && len_next == '0)) begin
                err_next = 1'b1;
            end else if (phase_next == PH_BARE || phase_next == PH_QUOTED) begin
                if (tgt_next) begin
                    omode_next = app_next ? OMODE_APPEND : OMODE_TRUNCATE;
                end else begin
                    imode_next = 1'b1;
                end
            end
            out_beat.line_done   = 1'b1;
            out_beat.parse_error = err_next;
            out_beat.input_mode  = imode_next;
            out_beat.output_mode = omode_next;
            phase_next = PH_NORMAL;
            qopen_next = 1'b0;
            qdq_next   = 1'b0;
            tgt_next   = 1'b0;
            app_next   = 1'b0;
            len_next   = '0;
            imode_next = 1'b0;
            omode_next = OMODE_NONE;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            qopen_reg <= 1'b0;
            qdq_reg   <= 1'b0;
            tgt_reg   <= 1'b0;
            app_reg   <= 1'b0;
            len_reg   <= '0;
            imode_reg <= 1'b0;
            omode_reg <= OMODE_NONE;
            err_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            qopen_reg <= qopen_next;
            qdq_reg   <= qdq_next;
            tgt_reg   <= tgt_next;
            app_reg   <= app_next;
            len_reg   <= len_next;
            imode_reg <= imode_next;
            omode_reg <= omode_next;
            err_reg   <= err_next;
        end
    end

endmodule

[rtl/shell_redirect_extractor.sv]
// Byte-serial shell redirect extractor. Each input beat is one byte of a
// command line; each yields exactly one result beat, in order. A byte enters
// an input register, is parsed against the quote/redirect state, and lands
// in a result register, so the block sustains one byte per clock unless
// m_ready stalls; the parser state, updated as each byte is parsed, sets
// that rate. Stalls on m_ready back up into s_ready without loss.
// The result of the end_of_line byte carries line_done with the final error
// flag and redirect modes, and the parser state clears for the next line.
module shell_redirect_extractor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srx_pkg::srx_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output srx_pkg::srx_out_t m_data
);
    import srx_pkg::*;

    logic     in_valid_reg, in_valid_next;
    srx_in_t  in_beat_reg, in_beat_next;
    logic     out_valid_reg, out_valid_next;
    srx_out_t out_beat_reg, out_beat_next;
    srx_out_t parse_beat;
    logic     advance, step;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step    = in_valid_reg && advance;

    srx_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_beat  (in_beat_reg),
        .out_beat (parse_beat)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_beat_next   = in_beat_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_beat_next  = s_data;
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_beat_next  = parse_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_beat_reg  <= in_beat_next;
        out_beat_reg <= out_beat_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    a_name_blanked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.name_valid |-> m_data.out_char == CHAR_SPACE)
        else $error("filename beat not blanked");

    a_summary_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.line_done |->
            !m_data.parse_error && !m_data.input_mode && m_data.output_mode == OMODE_NONE)
        else $error("summary fields set on a non-final beat");

    a_omode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.output_mode != 2'd3)
        else $error("illegal output mode");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_beat_reg))
        else $error("input register lost a byte under stall");

endmodule

[bench/tb_top.sv]
import srx_pkg::*;

class redirect_scoreboard;

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_AFTER_GT,
        SCAN_SKIP,
        SCAN_BARE,
        SCAN_QUOTED,
        SCAN_ERROR
    } scan_e;

    scan_e       phase;
    logic [7:0]  quote_ch;
    bit          tgt_out;
    bit          append;
    int unsigned name_len;
    bit          in_mode;
    logic [1:0]  out_mode;
    bit          err;

    srx_out_t    expected_q[$];
    int unsigned mismatches;
    int unsigned beats_checked;

    function new();
        clear_line();
        mismatches = 0;
        beats_checked = 0;
    endfunction

    function void clear_line();
        phase = SCAN_NORMAL;
        quote_ch = 8'h00;
        tgt_out = 1'b0;
        append = 1'b0;
        name_len = 0;
        in_mode = 1'b0;
        out_mode = OMODE_NONE;
        err = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    function bit is_quote(logic [7:0] c);
        return c == CHAR_DQ || c == CHAR_SQ;
    endfunction

    function bit is_term(logic [7:0] c);
        return c == CHAR_LT || c == CHAR_GT || c == CHAR_PIPE;
    endfunction

    function void raise_err();
        err = 1'b1;
        phase = SCAN_ERROR;
        quote_ch = 8'h00;
    endfunction

    function void commit();
        if (tgt_out) begin
            out_mode = append ? OMODE_APPEND : OMODE_TRUNCATE;
        end else begin
            in_mode = 1'b1;
        end
    endfunction

    function void store_name(inout srx_out_t r);
        r.out_char = CHAR_SPACE;
        if (name_len < NAME_MAX_BYTES - 1) begin
            r.name_valid = 1'b1;
            r.name_target = tgt_out;
            r.name_index = (name_len > 255) ? 8'hFF : 8'(name_len);
            name_len++;
        end
    endfunction

    function void scan_normal(logic [7:0] c, inout srx_out_t r);
        if (quote_ch != 8'h00) begin
            if (c == quote_ch) begin
                quote_ch = 8'h00;
            end
        end else if (is_quote(c)) begin
            quote_ch = c;
        end else if (c == CHAR_GT || c == CHAR_LT) begin
            r.out_char = CHAR_SPACE;
            tgt_out = (c == CHAR_GT);
            append = 1'b0;
            name_len = 0;
            if (c == CHAR_GT) begin
                phase = SCAN_AFTER_GT;
            end else begin
                phase = SCAN_SKIP;
            end
        end
    endfunction

    function void scan_skip(logic [7:0] c, inout srx_out_t r);
        if (is_blank(c)) begin
            r.out_char = CHAR_SPACE;
        end else if (is_quote(c)) begin
            r.out_char = CHAR_SPACE;
            quote_ch = c;
            name_len = 0;
            phase = SCAN_QUOTED;
        end else if (is_term(c)) begin
            raise_err();
        end else begin
            name_len = 0;
            phase = SCAN_BARE;
            store_name(r);
        end
    endfunction

    function void note_byte(srx_in_t b);
        srx_out_t   r;
        logic [7:0] c;
        c = b.line_char;
        r = '0;
        r.out_char = c;
        case (phase)
            SCAN_AFTER_GT: begin
                phase = SCAN_SKIP;
                if (c == CHAR_GT) begin
                    r.out_char = CHAR_SPACE;
                    append = 1'b1;
                end else begin
                    scan_skip(c, r);
                end
            end
            SCAN_SKIP: begin
                scan_skip(c, r);
            end
            SCAN_BARE: begin
                if (is_blank(c) || is_term(c)) begin
                    commit();
                    phase = SCAN_NORMAL;
                    scan_normal(c, r);
                end else begin
                    store_name(r);
                end
            end
            SCAN_QUOTED: begin
                if (c == quote_ch) begin
                    quote_ch = 8'h00;
                    if (name_len == 0) begin
                        raise_err();
                    end else begin
                        r.out_char = CHAR_SPACE;
                        commit();
                        phase = SCAN_NORMAL;
                    end
                end else begin
                    store_name(r);
                end
            end
            SCAN_ERROR: begin
            end
            default: begin
                phase = SCAN_NORMAL;
                scan_normal(c, r);
            end
        endcase
        if (b.end_of_line) begin
            if (phase == SCAN_AFTER_GT || phase == SCAN_SKIP) begin
                raise_err();
            end else if (phase == SCAN_BARE) begin
                commit();
            end else if (phase == SCAN_QUOTED) begin
                if (name_len == 0) begin
                    raise_err();
                end else begin
                    commit();
                end
            end
            r.line_done = 1'b1;
            r.parse_error = err;
            r.input_mode = in_mode;
            r.output_mode = out_mode;
            clear_line();
        end
        expected_q.push_back(r);
    endfunction

    function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(srx_out_t got);
        srx_out_t want;
        beats_checked++;
        if (expected_q.size() == 0) begin
            $error("result beat with no byte outstanding");
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        cmp_field("out_char", 32'(want.out_char), 32'(got.out_char));
        cmp_field("name_valid", 32'(want.name_valid), 32'(got.name_valid));
        cmp_field("name_target", 32'(want.name_target), 32'(got.name_target));
        cmp_field("name_index", 32'(want.name_index), 32'(got.name_index));
        cmp_field("line_done", 32'(want.line_done), 32'(got.line_done));
        cmp_field("parse_error", 32'(want.parse_error), 32'(got.parse_error));
        cmp_field("input_mode", 32'(want.input_mode), 32'(got.input_mode));
        cmp_field("output_mode", 32'(want.output_mode), 32'(got.output_mode));
    endfunction

endclass

module tb_top;

    typedef logic [7:0] byte_q_t[$];

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    srx_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    srx_out_t m_data;

    redirect_scoreboard sb = new();

    int unsigned bytes_sent = 0;
    int unsigned send_calm  = 0;

    string directed_lines[7] = '{
        "a>>b",
        "<'x'\t>y",
        "> |q",
        "<\"\"",
        ">",
        "\"a<b",
        ">'z"
    };

    always #2 aclk = ~aclk;

    shell_redirect_extractor DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // mostly short idles, a few long ones, and occasional idle-free stretches
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) begin
            return 8'($urandom_range(97, 122));
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LT || c == CHAR_GT ||
                   c == CHAR_PIPE);
        return c;
    endfunction

    function automatic logic [7:0] text_char(logic [7:0] qc);
        logic [7:0] c;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(97, 122));
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: return CHAR_LT;
                1: return CHAR_GT;
                2: return CHAR_PIPE;
                default: return CHAR_SPACE;
            endcase
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == qc);
        return c;
    endfunction

    function automatic logic [7:0] pick_quote();
        return $urandom_range(0, 1) ? CHAR_DQ : CHAR_SQ;
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    function automatic void build_line(output byte_q_t q, input bit want_long);
        int unsigned ntok;
        int unsigned sel;
        logic [7:0]  qc;
        bit          stop;
        q = {};
        stop = 1'b0;
        if (want_long) begin
            q.push_back(CHAR_GT);
            repeat ($urandom_range(250, 300)) q.push_back(name_char());
        end
        ntok = $urandom_range(1, 7);
        for (int t = 0; t < ntok && !stop; t++) begin
            sel = $urandom_range(0, 99);
            if (sel < 28) begin
                repeat ($urandom_range(1, 6)) q.push_back(name_char());
            end else if (sel < 42) begin
                repeat ($urandom_range(1, 2)) q.push_back(pick_blank());
            end else if (sel < 75) begin
                case ($urandom_range(0, 2))
                    0: q.push_back(CHAR_LT);
                    1: q.push_back(CHAR_GT);
                    default: begin
                        q.push_back(CHAR_GT);
                        q.push_back(CHAR_GT);
                    end
                endcase
                repeat ($urandom_range(0, 3) / 2 + $urandom_range(0, 1) * $urandom_range(0, 1))
                    q.push_back(pick_blank());
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    repeat ($urandom_range(1, 8)) q.push_back(name_char());
                end else if (sel < 80) begin
                    qc = pick_quote();
                    q.push_back(qc);
                    repeat ($urandom_range(1, 6)) q.push_back(text_char(qc));
                    q.push_back(qc);
                end else if (sel < 86) begin
                    qc = pick_quote();
                    q.push_back(qc);
                    q.push_back(qc);
                end else if (sel < 93) begin
                    // no name: either the line ends or an operator follows
                    case ($urandom_range(0, 3))
                        0: stop = 1'b1;
                        1: q.push_back(CHAR_LT);
                        2: q.push_back(CHAR_GT);
                        default: q.push_back(CHAR_PIPE);
                    endcase
                end else begin
                    qc = pick_quote();
                    q.push_back(qc);
                    repeat ($urandom_range(0, 5)) q.push_back(text_char(qc));
                    stop = 1'b1;
                end
            end else if (sel < 86) begin
                qc = pick_quote();
                q.push_back(qc);
                repeat ($urandom_range(0, 6)) q.push_back(text_char(qc));
                if ($urandom_range(0, 4) != 0) begin
                    q.push_back(qc);
                end else begin
                    stop = 1'b1;
                end
            end else if (sel < 92) begin
                q.push_back(CHAR_PIPE);
            end else begin
                q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (q.size() == 0) begin
            q.push_back(name_char());
        end
    endfunction

    task automatic send_byte(input srx_in_t b);
        int unsigned gap;
        gap = pick_idle(send_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line(input byte_q_t q);
        srx_in_t b;
        for (int i = 0; i < q.size(); i++) begin
            b.line_char   = q[i];
            b.end_of_line = (i == q.size() - 1);
            send_byte(b);
        end
    endtask

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned stall_left;
        int unsigned calm;
        bit          held;
        stall_left = 0;
        calm = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            // one long hold-off so the input side backs up
            if (!held && sb.beats_checked >= 400) begin
                held = 1'b1;
                stall_left = 300;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_idle(calm);
                m_ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        byte_q_t cmd_line;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_lines[i]) begin
            cmd_line = {};
            for (int k = 0; k < directed_lines[i].len(); k++) begin
                cmd_line.push_back(directed_lines[i][k]);
            end
            send_line(cmd_line);
        end
        build_line(cmd_line, 1'b1);
        send_line(cmd_line);
        while (bytes_sent < 1350) begin
            build_line(cmd_line, $urandom_range(0, 29) == 0);
            send_line(cmd_line);
        end
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
